[rtl/wfd_pkg.sv]
// ----------------------------------------------------------------------------
// wfd_pkg
// Shared constants and types of the wait-for deadlock detector.
// ----------------------------------------------------------------------------
`default_nettype none
package wfd_pkg;
	localparam int ENTRIES = 16;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int ID_W    = 64;
	localparam int QDEPTH  = 2;

	localparam logic CMD_BEGIN = 1'b0;
	localparam logic CMD_END   = 1'b1;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_SAME    = 3'd1;
	localparam logic [2:0] ST_DUP     = 3'd2;
	localparam logic [2:0] ST_FULL    = 3'd3;
	localparam logic [2:0] ST_NOMATCH = 3'd4;
	localparam logic [2:0] ST_LIMIT   = 3'd5;

	typedef struct packed {
		logic            cmd;
		logic            same;
		logic [ID_W-1:0] caller;
		logic [ID_W-1:0] target;
	} req_t;
endpackage
`default_nettype wire

[rtl/wait_for_deadlock_detector_core.sv]
// ----------------------------------------------------------------------------
// wait_for_deadlock_detector_core
// Wait-for graph deadlock detector: request queue in front, edge table behind.
// ----------------------------------------------------------------------------
// A request passes the front queue, then the back end's check state; a begin walks one
// edge per cycle, then a deadlock report emits one result per cycle while not stalled.
// The back end takes the next request only after the last result of the current one.
// Reset: arst_n clears the queue, state and all entry valid bits at once.
`default_nettype none
module wait_for_deadlock_detector_core (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [127:0] s_tdata,   // caller_id[63:0], target_id[127:64]
	input  wire logic         s_tuser,   // cmd
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [71:0]       m_tdata,   // chain_thread[63:0], status[66:64], zero
	output logic              m_tuser,   // deadlock
	output logic              m_tlast
);
	logic          q_valid;
	logic          q_ready;
	wfd_pkg::req_t q_req;

	wfd_front u_front (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
	);

	wfd_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);
endmodule
`default_nettype wire

[rtl/wfd_front.sv]
// ----------------------------------------------------------------------------
// wfd_front
// Accepts requests, flags same-thread calls and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module wfd_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire logic [127:0]  s_tdata,
	input  wire logic          s_tuser,
	output logic               q_valid,
	input  wire logic          q_ready,
	output wfd_pkg::req_t      q_req
);
	wfd_pkg::req_t  mem_q [wfd_pkg::QDEPTH];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           push;
	logic           pop;
	wfd_pkg::req_t  in_req;

	assign s_tready = (count_q != 2'(wfd_pkg::QDEPTH));
	assign q_valid  = (count_q != 2'd0);
	assign push     = s_tvalid && s_tready;
	assign pop      = q_valid && q_ready;
	assign q_req    = mem_q[rd_ptr_q];

	always_comb begin
		in_req.cmd    = s_tuser;
		in_req.caller = s_tdata[63:0];
		in_req.target = s_tdata[127:64];
		in_req.same   = (s_tdata[63:0] == s_tdata[127:64]);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end
endmodule
`default_nettype wire

[rtl/wfd_back.sv]
// ----------------------------------------------------------------------------
// wfd_back
// Edge table, chain walk and result emission.
// ----------------------------------------------------------------------------
`default_nettype none
module wfd_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_valid,
	output logic               q_ready,
	input  wire wfd_pkg::req_t q_req,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output logic [71:0]        m_tdata,
	output logic               m_tuser,
	output logic               m_tlast
);
	typedef enum logic [2:0] {
		S_IDLE, S_CHECK, S_WALK, S_RESP, S_EMIT, S_EMIT_LAST
	} state_t;

	state_t                        state_q;
	wfd_pkg::req_t                 req_q;
	logic [wfd_pkg::IDX_W-1:0]     cur_q;
	logic [wfd_pkg::IDX_W-1:0]     start_q;
	logic [wfd_pkg::CNT_W-1:0]     steps_q;
	logic [2:0]                    res_status_q;

	logic [wfd_pkg::ENTRIES-1:0]   valid_q;
	logic [wfd_pkg::ID_W-1:0]      waiter_q  [wfd_pkg::ENTRIES];
	logic [wfd_pkg::ID_W-1:0]      awaited_q [wfd_pkg::ENTRIES];

	logic                          m_valid_q;
	logic [71:0]                   m_data_q;
	logic                          m_user_q;
	logic                          m_last_q;

	logic [wfd_pkg::ENTRIES-1:0]   caller_hit;
	logic [wfd_pkg::ENTRIES-1:0]   next_hit;
	logic [wfd_pkg::ID_W-1:0]      cur_awaited;
	logic                          caller_found;
	logic [wfd_pkg::IDX_W-1:0]     caller_idx;
	logic                          free_found;
	logic [wfd_pkg::IDX_W-1:0]     free_idx;
	logic                          next_found;
	logic [wfd_pkg::IDX_W-1:0]     next_idx;
	logic                          can_load;
	logic                          out_load;
	logic                          tbl_set;
	logic                          tbl_clr;

	function automatic logic [wfd_pkg::IDX_W:0] first_set(
		input logic [wfd_pkg::ENTRIES-1:0] vec
	);
		logic [wfd_pkg::IDX_W:0] res;
		res = '0;
		for (int i = wfd_pkg::ENTRIES - 1; i >= 0; i--) begin
			if (vec[i]) res = {1'b1, wfd_pkg::IDX_W'(i)};
		end
		return res;
	endfunction

	assign cur_awaited = awaited_q[cur_q];

	always_comb begin
		for (int i = 0; i < wfd_pkg::ENTRIES; i++) begin
			caller_hit[i] = valid_q[i] && (waiter_q[i] == req_q.caller);
			next_hit[i]   = valid_q[i] && (waiter_q[i] == cur_awaited);
		end
	end

	assign {caller_found, caller_idx} = first_set(caller_hit);
	assign {free_found, free_idx}     = first_set(~valid_q);
	assign {next_found, next_idx}     = first_set(next_hit);

	assign can_load = !m_valid_q || m_tready;
	assign out_load = can_load && (state_q inside {S_RESP, S_EMIT, S_EMIT_LAST});
	assign q_ready  = (state_q == S_IDLE);
	assign tbl_set  = (state_q == S_CHECK) && (req_q.cmd == wfd_pkg::CMD_BEGIN) &&
			!req_q.same && !caller_found && free_found;
	assign tbl_clr  = (state_q == S_CHECK) && (req_q.cmd == wfd_pkg::CMD_END) &&
			!req_q.same && caller_found && (awaited_q[caller_idx] == req_q.target);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (tbl_set) begin
			valid_q[free_idx] <= 1'b1;
		end else if (tbl_clr) begin
			valid_q[caller_idx] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tbl_set) begin
			waiter_q[free_idx]  <= req_q.caller;
			awaited_q[free_idx] <= req_q.target;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			m_valid_q    <= 1'b0;
			req_q        <= '0;
			cur_q        <= '0;
			start_q      <= '0;
			steps_q      <= '0;
			res_status_q <= wfd_pkg::ST_OK;
			m_data_q     <= '0;
			m_user_q     <= 1'b0;
			m_last_q     <= 1'b0;
		end else begin
			if (out_load) m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						req_q   <= q_req;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					state_q <= S_RESP;
					if (req_q.same) begin
						res_status_q <= wfd_pkg::ST_SAME;
					end else if (req_q.cmd == wfd_pkg::CMD_END) begin
						res_status_q <= tbl_clr ? wfd_pkg::ST_OK : wfd_pkg::ST_NOMATCH;
					end else if (caller_found) begin
						res_status_q <= wfd_pkg::ST_DUP;
					end else if (!free_found) begin
						res_status_q <= wfd_pkg::ST_FULL;
					end else begin
						cur_q   <= free_idx;
						start_q <= free_idx;
						steps_q <= '0;
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (cur_awaited == req_q.caller) begin
						cur_q   <= start_q;
						state_q <= S_EMIT;
					end else if (!next_found) begin
						res_status_q <= wfd_pkg::ST_OK;
						state_q      <= S_RESP;
					end else if (steps_q == wfd_pkg::CNT_W'(wfd_pkg::ENTRIES - 1)) begin
						res_status_q <= wfd_pkg::ST_LIMIT;
						state_q      <= S_RESP;
					end else begin
						cur_q   <= next_idx;
						steps_q <= steps_q + 1'b1;
					end
				end
				S_RESP: begin
					if (can_load) begin
						m_data_q  <= {5'd0, res_status_q, 64'd0};
						m_user_q  <= 1'b0;
						m_last_q  <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				S_EMIT: begin
					if (can_load) begin
						m_data_q  <= {5'd0, wfd_pkg::ST_OK, waiter_q[cur_q]};
						m_user_q  <= 1'b1;
						m_last_q  <= 1'b0;
						if (cur_awaited == req_q.caller) state_q <= S_EMIT_LAST;
						else cur_q <= next_idx;
					end
				end
				S_EMIT_LAST: begin
					if (can_load) begin
						m_data_q  <= {5'd0, wfd_pkg::ST_OK, req_q.caller};
						m_user_q  <= 1'b1;
						m_last_q  <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;
	assign m_tlast  = m_last_q;
endmodule
`default_nettype wire

[rtl/wfd_checker.sv]
// ----------------------------------------------------------------------------
// wfd_checker
// Port-level checks of the deadlock detector result stream.
// ----------------------------------------------------------------------------
`default_nettype none
module wfd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [71:0] m_tdata,
	input wire logic        m_tuser,
	input wire logic        m_tlast
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped under stall");
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast)
		else $error("non-deadlock result not last");
	a_zero_chain: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[63:0] == 64'd0)
		else $error("chain id outside deadlock report");
	a_dl_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[66:64] == wfd_pkg::ST_OK)
		else $error("deadlock result with error status");
endmodule

bind wait_for_deadlock_detector_core wfd_checker u_wfd_checker (
	.clk(clk), .arst_n(arst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
	.m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
);
`default_nettype wire
